### rtl/core/cbpa_pkg.sv
// Package for the client busy-period accounting core.
// Holds op codes, sequencer states, register indexes and the record type.
// No dependencies.
package cbpa_pkg;

  localparam int unsigned ONE_SEC_NS = 32'd1000000000;

  localparam int unsigned TS_W     = 64;
  localparam int unsigned CLIENT_W = 4;
  localparam int unsigned DEV_W    = 8;
  localparam int unsigned PERIOD_W = 32;
  localparam int unsigned CFG_W    = 32;
  localparam int unsigned CFG_IDX_W = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEVICE = 1'd1;

  typedef enum logic [1:0] {
    OP_OPEN  = 2'd0,
    OP_START = 2'd1,
    OP_END   = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SPLIT
  } state_e;

  // One report record
  typedef struct packed {
    logic [CLIENT_W-1:0] client;
    logic [DEV_W-1:0]    device;
    logic [TS_W-1:0]     period_start;
    logic [TS_W-1:0]     period_end;
    logic [TS_W-1:0]     active_ns;
    logic                truncated;
    logic                last;
  } rec_t;

endpackage

### rtl/core/client_busy_period_accounting_core.sv
// Client busy-period accounting core: per-slot job counts, busy start times,
// and a sequencer that splits busy spans into period records.
// Depends on cbpa_pkg.
//
// Usage: events enter on the in channel (valid/ready) as op, client slot and
// timestamp. Records leave on the out channel (valid/ready), one per beat,
// with last set on the final record of an event. Configuration (period_ns,
// device_id) is written through cfg_we_i/cfg_idx_i/cfg_wdata_i. The user
// must write it only while idle; the block itself does not enforce this.
// Sequence: one item is taken every time the sequencer is back in idle. An
// item passes through idle (table read), then execute (table update), and for
// a job end through the split state, which emits its records one by one. A
// record appears on the outputs in the cycle after it is built. The split
// state uses the single shared 64-bit subtract/compare/add unit.
// Reset: all counts and start times read as zero (per-entry valid bits are
// cleared), period_ns returns to one second, device_id to zero. No output is
// pending after reset.
// Stall: while the output register holds an untaken record, the sequencer
// waits in place; a new item is accepted even while the last record waits.
module client_busy_period_accounting_core #(
  parameter int unsigned NUM_CLIENTS = 16,
  parameter int unsigned MAX_RECORDS = 64,
  parameter int unsigned COUNT_BITS  = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration write port
  input  logic                             cfg_we_i,
  input  logic [cbpa_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [cbpa_pkg::CFG_W-1:0]       cfg_wdata_i,
  // event input
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [1:0]                       op_i,
  input  logic [cbpa_pkg::CLIENT_W-1:0]    client_i,
  input  logic [cbpa_pkg::TS_W-1:0]        now_i,
  // record output
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [cbpa_pkg::CLIENT_W-1:0]    client_out_o,
  output logic [cbpa_pkg::DEV_W-1:0]       device_out_o,
  output logic [cbpa_pkg::TS_W-1:0]        period_start_o,
  output logic [cbpa_pkg::TS_W-1:0]        period_end_o,
  output logic [cbpa_pkg::TS_W-1:0]        active_ns_o,
  output logic                             truncated_o,
  output logic                             last_o
);

  localparam int unsigned IDX_W = (NUM_CLIENTS > 1) ? $clog2(NUM_CLIENTS) : 1;
  localparam int unsigned REC_W = $clog2(MAX_RECORDS);
  localparam logic [COUNT_BITS-1:0] CNT_MAX  = {COUNT_BITS{1'b1}};
  localparam logic [REC_W-1:0]      LAST_IDX = REC_W'(MAX_RECORDS - 1);
  localparam int unsigned TS_W = cbpa_pkg::TS_W;

  // configuration registers
  logic [cbpa_pkg::PERIOD_W-1:0] period_q;
  logic [cbpa_pkg::DEV_W-1:0]    device_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= cbpa_pkg::PERIOD_W'(cbpa_pkg::ONE_SEC_NS);
      device_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        cbpa_pkg::CFG_PERIOD: period_q <= cfg_wdata_i[cbpa_pkg::PERIOD_W-1:0];
        cbpa_pkg::CFG_DEVICE: device_q <= cfg_wdata_i[cbpa_pkg::DEV_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer and latched item
  cbpa_pkg::state_e                state_q, state_d;
  cbpa_pkg::op_e                   op_q;
  logic [cbpa_pkg::CLIENT_W-1:0]   client_q;
  logic [TS_W-1:0]                 now_q;
  logic [TS_W-1:0]                 cursor_q, cursor_d;
  logic [REC_W-1:0]                ridx_q, ridx_d;
  logic                            in_acc;

  assign in_ready_o = (state_q == cbpa_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q     <= cbpa_pkg::op_e'(op_i);
      client_q <= client_i;
      now_q    <= now_i;
    end
  end

  // client table: count and start memories with per-entry valid bits
  logic [COUNT_BITS-1:0]  cnt_mem [NUM_CLIENTS];
  logic [TS_W-1:0]        start_mem [NUM_CLIENTS];
  logic [NUM_CLIENTS-1:0] cnt_vld_q, start_vld_q;
  logic [COUNT_BITS-1:0]  cnt_rd_q, cnt_wd, cnt_cur;
  logic [TS_W-1:0]        start_rd_q, start_cur;
  logic                   cnt_we, start_we, cnt_clr;
  logic [IDX_W-1:0]       idx, rd_idx;
  logic                   in_range;

  assign idx      = IDX_W'(client_q);
  assign rd_idx   = IDX_W'(client_i);
  assign in_range = (32'(client_q) < NUM_CLIENTS);

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cnt_rd_q   <= cnt_mem[rd_idx];
      start_rd_q <= start_mem[rd_idx];
    end
    if (cnt_we) begin
      cnt_mem[idx] <= cnt_wd;
    end
    if (start_we) begin
      start_mem[idx] <= now_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_vld_q   <= '0;
      start_vld_q <= '0;
    end else begin
      if (cnt_clr) begin
        cnt_vld_q <= '0;
      end else if (cnt_we) begin
        cnt_vld_q[idx] <= 1'b1;
      end
      if (start_we) begin
        start_vld_q[idx] <= 1'b1;
      end
    end
  end

  // entries never written read as zero
  assign cnt_cur   = cnt_vld_q[idx]   ? cnt_rd_q   : '0;
  assign start_cur = start_vld_q[idx] ? start_rd_q : '0;

  // shared split unit: remaining span, compare against period, next cursor
  logic [TS_W-1:0] p64, diff, cursor_nxt;
  logic            over;

  assign p64        = TS_W'(period_q);
  assign diff       = now_q - cursor_q;
  assign over       = (diff > p64);
  assign cursor_nxt = cursor_q + p64;

  // output register
  cbpa_pkg::rec_t rec_q, rec_d;
  logic           out_valid_q, rec_load, out_free;

  assign out_free = !out_valid_q || out_ready_i;

  // next state and datapath control
  always_comb begin
    state_d  = state_q;
    cursor_d = cursor_q;
    ridx_d   = ridx_q;
    cnt_we   = 1'b0;
    cnt_wd   = '0;
    start_we = 1'b0;
    cnt_clr  = 1'b0;
    rec_load = 1'b0;
    rec_d    = '0;
    rec_d.client = client_q;
    rec_d.device = device_q;
    case (state_q)
      cbpa_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_d = cbpa_pkg::ST_EXEC;
        end
      end
      cbpa_pkg::ST_EXEC: begin
        case (op_q)
          cbpa_pkg::OP_CLEAR: begin
            cnt_clr = 1'b1;
            state_d = cbpa_pkg::ST_IDLE;
          end
          cbpa_pkg::OP_OPEN: begin
            if (!in_range) begin
              state_d = cbpa_pkg::ST_IDLE;
            end else if (out_free) begin
              cnt_we             = 1'b1;
              cnt_wd             = '0;
              start_we           = 1'b1;
              rec_load           = 1'b1;
              rec_d.period_start = now_q;
              rec_d.period_end   = now_q + TS_W'(1);
              rec_d.last         = 1'b1;
              state_d            = cbpa_pkg::ST_IDLE;
            end
          end
          cbpa_pkg::OP_START: begin
            // saturating increment; first job marks the busy start
            if (in_range && (cnt_cur != CNT_MAX)) begin
              cnt_we   = 1'b1;
              cnt_wd   = cnt_cur + COUNT_BITS'(1);
              start_we = (cnt_cur == '0);
            end
            state_d = cbpa_pkg::ST_IDLE;
          end
          cbpa_pkg::OP_END: begin
            state_d = cbpa_pkg::ST_IDLE;
            if (in_range) begin
              // count drops even when start lies in the future
              if (cnt_cur != '0) begin
                cnt_we = 1'b1;
                cnt_wd = cnt_cur - COUNT_BITS'(1);
              end
              if (start_cur <= now_q) begin
                cursor_d = start_cur;
                ridx_d   = '0;
                state_d  = cbpa_pkg::ST_SPLIT;
              end
            end
          end
          default: state_d = cbpa_pkg::ST_IDLE;
        endcase
      end
      cbpa_pkg::ST_SPLIT: begin
        if (out_free) begin
          rec_load           = 1'b1;
          rec_d.period_start = cursor_q;
          if ((ridx_q < LAST_IDX) && over) begin
            // one full period
            rec_d.period_end = cursor_nxt;
            rec_d.active_ns  = p64;
            cursor_d         = cursor_nxt;
            ridx_d           = ridx_q + REC_W'(1);
          end else begin
            // remainder record, flagged truncated if periods were left over
            rec_d.period_end = now_q;
            rec_d.active_ns  = diff;
            rec_d.truncated  = over;
            rec_d.last       = 1'b1;
            start_we         = 1'b1;
            state_d          = cbpa_pkg::ST_IDLE;
          end
        end
      end
      default: state_d = cbpa_pkg::ST_IDLE;
    endcase
  end

  // state and split registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= cbpa_pkg::ST_IDLE;
      cursor_q <= '0;
      ridx_q   <= '0;
    end else begin
      state_q  <= state_d;
      cursor_q <= cursor_d;
      ridx_q   <= ridx_d;
    end
  end

  // output stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rec_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rec_load) begin
      rec_q <= rec_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign client_out_o   = rec_q.client;
  assign device_out_o   = rec_q.device;
  assign period_start_o = rec_q.period_start;
  assign period_end_o   = rec_q.period_end;
  assign active_ns_o    = rec_q.active_ns;
  assign truncated_o    = rec_q.truncated;
  assign last_o         = rec_q.last;

endmodule
